// ===== src/cau_pkg.sv =====
// Shared opcodes, status codes and CORDIC angle constants for the complex arithmetic unit.
package cau_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_NEG     = 4'd2,
    OP_MUL     = 4'd3,
    OP_SCALE   = 4'd4,
    OP_DIV     = 4'd5,
    OP_DIVREAL = 4'd6,
    OP_CONJ    = 4'd7,
    OP_ABS2    = 4'd8,
    OP_ABS     = 4'd9,
    OP_ARG     = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } st_e;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
  };

  function automatic logic [63:0] q30_to_frac(input logic [63:0] t, input int fb);
    logic [63:0] r;
    if (fb <= 30) begin
      r = t >> (30 - fb);
    end else begin
      r = t << (fb - 30);
    end
    return r;
  endfunction

endpackage

// ===== src/cau_div.sv =====
// Pipelined restoring divider: floor(num * 2^FB / den), one quotient bit per stage.
module cau_div
  import cau_pkg::*;
#(
  parameter int NW = 64,
  parameter int FB = 16,
  parameter int QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int RW = NW + ((FB > QW) ? FB : QW);

  logic [RW-1:0] rem_q [QW+1];
  logic [NW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  logic [RW-1:0] num_sh;
  logic [RW-1:0] den_sh;

  assign num_sh = RW'({num_i, {FB{1'b0}}});
  assign den_sh = RW'({den_i, {QW{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_sh;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (num_sh >= den_sh);
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int K = QW - j;
    logic [RW-1:0] trial;
    logic          take;
    logic [QW-1:0] quo_nx;
    assign trial  = RW'(den_q[j-1]) << K;
    assign take   = (rem_q[j-1] >= trial);
    assign quo_nx = quo_q[j-1] | (QW'(take) << K);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? (rem_q[j-1] - trial) : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= quo_nx;
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ===== src/cau_cordic.sv =====
// Pipelined CORDIC vectoring unit giving atan2(y, x) in radians with FB fraction bits.
module cau_cordic
  import cau_pkg::*;
#(
  parameter int W  = 32,
  parameter int FB = 16,
  parameter int NS = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [W-1:0]    x_i,
  input  logic signed [W-1:0]    y_i,
  output logic signed [FB+3:0]   z_o
);

  localparam int CW = W + 3;
  localparam int ZW = FB + 4;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(q30_to_frac(PI_Q30, FB));

  logic signed [CW-1:0] x_q [NS+1];
  logic signed [CW-1:0] y_q [NS+1];
  logic signed [ZW-1:0] z_q [NS+1];

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;

  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= (y_i >= 0) ? PI_Z : -PI_Z;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] AT = ZW'(q30_to_frac(64'(ATAN_Q30[i]), FB));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + AT;
        end else if (y_q[i] < 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i];
          y_q[i+1] <= y_q[i];
          z_q[i+1] <= z_q[i];
        end
      end
    end
  end

  assign z_o = z_q[NS];

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// Top level of the pipelined complex arithmetic unit in signed fixed point.
//
// Channel  Dir  tdata (low bit up)                       tuser
// s_axis   in   a_re[31:0] a_im[63:32] b_re[95:64]       func[3:0]
//               b_im[127:96]
// m_axis   out  res_re[31:0] res_im[63:32]                status[1:0]
//
// One request per cycle while m_axis is not stalled; the divider lanes have W+1
// quotient-bit stages each (W = min(DATA_WIDTH, 32)).
// Reset clears only the valid bits; no clearing pass.
// A stall at m_axis parks one result in a skid register and then freezes the pipeline.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH   = 32,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_re, a_im, b_re, b_im
  input  logic [3:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // res_re, res_im
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int W    = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int NS   = CORDIC_STEPS;
  localparam int PW   = 2 * W;
  localparam int QW   = W + 1;
  localparam int ZW   = FB + 4;
  localparam int XW   = ((2 * W + 2) > (FB + 5)) ? (2 * W + 2) : (FB + 5);
  localparam int LAST = (((W + 4) > (NS + 1)) ? (W + 4) : (NS + 1)) + 1;
  localparam int D_SB = LAST - 2;
  localparam int D_DV = LAST - (W + 4);
  localparam int D_SQ = LAST - (W + 2);
  localparam int D_CO = LAST - (NS + 1);

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    op_e          op;
    logic [W-1:0] re;
    logic [W-1:0] im;
    logic         flag;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
  } sb_t;

  function automatic logic [W:0] sat_w(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[W-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] x);
    logic [W-1:0] r;
    r = x[W-1] ? W'(-x) : W'(x);
    return r;
  endfunction

  function automatic logic [W:0] quo_sat(input logic [QW-1:0] q, input logic ovf,
                                         input logic neg);
    logic signed [XW-1:0] v;
    logic [W:0]           r;
    v = $signed(XW'(q));
    if (neg) begin
      v = -v;
    end
    r = sat_w(v);
    if (ovf) begin
      r = neg ? {1'b1, SAT_LO[W-1:0]} : {1'b1, SAT_HI[W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic [LAST:0] vld_q;

  // stage 0: operands
  op_e                s0_op_q;
  logic signed [W-1:0] s0_ar_q, s0_ai_q, s0_br_q, s0_bi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_op_q <= op_e'(s_axis_tuser);
      s0_ar_q <= s_axis_tdata[0 +: W];
      s0_ai_q <= s_axis_tdata[32 +: W];
      s0_br_q <= s_axis_tdata[64 +: W];
      s0_bi_q <= s_axis_tdata[96 +: W];
    end
  end

  // stage 1: products and short ops
  logic signed [W-1:0] mx4, mx5;
  logic signed [W:0]   smp_re_x, smp_im_x;
  logic [W:0]          smp_re_s, smp_im_s;

  assign mx4 = (s0_op_q == OP_ABS2 || s0_op_q == OP_ABS) ? s0_ar_q : s0_br_q;
  assign mx5 = (s0_op_q == OP_ABS2 || s0_op_q == OP_ABS) ? s0_ai_q : s0_bi_q;

  always_comb begin
    smp_re_x = '0;
    smp_im_x = '0;
    case (s0_op_q)
      OP_ADD: begin
        smp_re_x = (W+1)'(s0_ar_q) + (W+1)'(s0_br_q);
        smp_im_x = (W+1)'(s0_ai_q) + (W+1)'(s0_bi_q);
      end
      OP_SUB: begin
        smp_re_x = (W+1)'(s0_ar_q) - (W+1)'(s0_br_q);
        smp_im_x = (W+1)'(s0_ai_q) - (W+1)'(s0_bi_q);
      end
      OP_NEG: begin
        smp_re_x = -(W+1)'(s0_ar_q);
        smp_im_x = -(W+1)'(s0_ai_q);
      end
      OP_CONJ: begin
        smp_re_x = (W+1)'(s0_ar_q);
        smp_im_x = -(W+1)'(s0_ai_q);
      end
      default: begin
        smp_re_x = '0;
        smp_im_x = '0;
      end
    endcase
  end

  assign smp_re_s = sat_w(XW'(smp_re_x));
  assign smp_im_s = sat_w(XW'(smp_im_x));

  op_e                  s1_op_q;
  logic signed [PW-1:0] s1_p_q [6];
  logic [W-1:0]         s1_smp_re_q, s1_smp_im_q;
  logic                 s1_smp_flag_q;
  logic [W-1:0]         s1_dr_nre_q, s1_dr_nim_q, s1_dr_den_q;
  logic                 s1_dr_neg_re_q, s1_dr_neg_im_q, s1_br_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q        <= s0_op_q;
      s1_p_q[0]      <= PW'(s0_ar_q) * PW'(s0_br_q);
      s1_p_q[1]      <= PW'(s0_ai_q) * PW'(s0_bi_q);
      s1_p_q[2]      <= PW'(s0_ar_q) * PW'(s0_bi_q);
      s1_p_q[3]      <= PW'(s0_ai_q) * PW'(s0_br_q);
      s1_p_q[4]      <= PW'(mx4) * PW'(mx4);
      s1_p_q[5]      <= PW'(mx5) * PW'(mx5);
      s1_smp_re_q    <= smp_re_s[W-1:0];
      s1_smp_im_q    <= smp_im_s[W-1:0];
      s1_smp_flag_q  <= smp_re_s[W] | smp_im_s[W];
      s1_dr_nre_q    <= abs_w(s0_ar_q);
      s1_dr_nim_q    <= abs_w(s0_ai_q);
      s1_dr_den_q    <= abs_w(s0_br_q);
      s1_dr_neg_re_q <= s0_ar_q[W-1] ^ s0_br_q[W-1];
      s1_dr_neg_im_q <= s0_ai_q[W-1] ^ s0_br_q[W-1];
      s1_br_zero_q   <= (s0_br_q == '0);
    end
  end

  // stage 2: product sums, truncating shift and saturation, divider operands
  logic signed [PW:0] e0, e1, e2, e3, a2_s, pr_re, pr_im, nd_re, nd_im;
  logic [W:0]         pr_re_s, pr_im_s;
  logic [PW-1:0]      den_c;
  sb_t                sb_c;
  logic [PW-1:0]      dv_nre_c, dv_nim_c, dv_den_c;

  assign e0    = (PW+1)'(s1_p_q[0]);
  assign e1    = (PW+1)'(s1_p_q[1]);
  assign e2    = (PW+1)'(s1_p_q[2]);
  assign e3    = (PW+1)'(s1_p_q[3]);
  assign a2_s  = (PW+1)'(s1_p_q[4]) + (PW+1)'(s1_p_q[5]);
  assign nd_re = e0 + e1;
  assign nd_im = e3 - e2;
  assign den_c = PW'(a2_s);

  always_comb begin
    pr_re = '0;
    pr_im = '0;
    case (s1_op_q)
      OP_MUL: begin
        pr_re = e0 - e1;
        pr_im = e2 + e3;
      end
      OP_SCALE: begin
        pr_re = e0;
        pr_im = e3;
      end
      OP_ABS2: begin
        pr_re = a2_s;
      end
      default: begin
        pr_re = '0;
        pr_im = '0;
      end
    endcase
  end

  assign pr_re_s = sat_w(XW'(pr_re >>> FB));
  assign pr_im_s = sat_w(XW'(pr_im >>> FB));

  always_comb begin
    sb_c.op     = s1_op_q;
    sb_c.re     = '0;
    sb_c.im     = '0;
    sb_c.flag   = 1'b0;
    sb_c.dz     = 1'b0;
    sb_c.neg_re = 1'b0;
    sb_c.neg_im = 1'b0;
    dv_nre_c    = PW'(s1_dr_nre_q);
    dv_nim_c    = PW'(s1_dr_nim_q);
    dv_den_c    = PW'(s1_dr_den_q);
    case (s1_op_q)
      OP_ADD, OP_SUB, OP_NEG, OP_CONJ: begin
        sb_c.re   = s1_smp_re_q;
        sb_c.im   = s1_smp_im_q;
        sb_c.flag = s1_smp_flag_q;
      end
      OP_MUL, OP_SCALE, OP_ABS2: begin
        sb_c.re   = pr_re_s[W-1:0];
        sb_c.im   = pr_im_s[W-1:0];
        sb_c.flag = pr_re_s[W] | pr_im_s[W];
      end
      OP_DIV: begin
        sb_c.dz     = (den_c == '0);
        sb_c.neg_re = nd_re[PW];
        sb_c.neg_im = nd_im[PW];
        dv_nre_c    = nd_re[PW] ? PW'(-nd_re) : PW'(nd_re);
        dv_nim_c    = nd_im[PW] ? PW'(-nd_im) : PW'(nd_im);
        dv_den_c    = den_c;
      end
      OP_DIVREAL: begin
        sb_c.dz     = s1_br_zero_q;
        sb_c.neg_re = s1_dr_neg_re_q;
        sb_c.neg_im = s1_dr_neg_im_q;
      end
      default: begin
        sb_c.flag = 1'b0;
      end
    endcase
  end

  sb_t           s2_sb_q;
  logic [PW-1:0] s2_nre_q, s2_nim_q, s2_den_q, s2_sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sb_q  <= sb_c;
      s2_nre_q <= dv_nre_c;
      s2_nim_q <= dv_nim_c;
      s2_den_q <= dv_den_c;
      s2_sq_q  <= den_c;
    end
  end

  // dividers
  logic [QW-1:0] quo_re, quo_im;
  logic          ovf_re, ovf_im;

  cau_div #(.NW(PW), .FB(FB), .QW(QW)) u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_nre_q),
    .den_i (s2_den_q),
    .quo_o (quo_re),
    .ovf_o (ovf_re)
  );

  cau_div #(.NW(PW), .FB(FB), .QW(QW)) u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s2_nim_q),
    .den_i (s2_den_q),
    .quo_o (quo_im),
    .ovf_o (ovf_im)
  );

  // square root, one root bit per stage
  logic [PW-1:0] sq_rem_q  [W];
  logic [PW-1:0] sq_root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam logic [PW-1:0] BIT = PW'(1) << (PW - 2 - 2 * k);
    logic [PW-1:0] rem_in, root_in, trial;
    if (k == 0) begin : g_first
      assign rem_in  = s2_sq_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
    end
    assign trial = root_in + BIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_in >= trial) begin
          sq_rem_q[k]  <= rem_in - trial;
          sq_root_q[k] <= (root_in >> 1) + BIT;
        end else begin
          sq_rem_q[k]  <= rem_in;
          sq_root_q[k] <= root_in >> 1;
        end
      end
    end
  end

  // argument
  logic signed [ZW-1:0] cor_z;

  cau_cordic #(.W(W), .FB(FB), .NS(NS)) u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s0_ar_q),
    .y_i   (s0_ai_q),
    .z_o   (cor_z)
  );

  // align all lanes at the merge stage
  sb_t                  sb_dly_q [D_SB];
  logic [2*QW+1:0]      dv_dly_q [D_DV];
  logic [W-1:0]         sq_dly_q [D_SQ];
  logic signed [ZW-1:0] co_dly_q [D_CO];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_dly_q[0] <= s2_sb_q;
      for (int k = 1; k < D_SB; k++) sb_dly_q[k] <= sb_dly_q[k-1];
      dv_dly_q[0] <= {quo_re, ovf_re, quo_im, ovf_im};
      for (int k = 1; k < D_DV; k++) dv_dly_q[k] <= dv_dly_q[k-1];
      sq_dly_q[0] <= sq_root_q[W-1][W-1:0];
      for (int k = 1; k < D_SQ; k++) sq_dly_q[k] <= sq_dly_q[k-1];
      co_dly_q[0] <= cor_z;
      for (int k = 1; k < D_CO; k++) co_dly_q[k] <= co_dly_q[k-1];
    end
  end

  // merge
  sb_t                 m_sb;
  logic [QW-1:0]       m_qre, m_qim;
  logic                m_ore, m_oim;
  logic [W:0]          m_dre, m_dim, m_sq, m_co;
  logic signed [W-1:0] mrg_re, mrg_im;
  st_e                 mrg_st;
  logic                mrg_flag;

  assign m_sb = sb_dly_q[D_SB-1];
  assign {m_qre, m_ore, m_qim, m_oim} = dv_dly_q[D_DV-1];
  assign m_dre = quo_sat(m_qre, m_ore, m_sb.neg_re);
  assign m_dim = quo_sat(m_qim, m_oim, m_sb.neg_im);
  assign m_sq  = sat_w($signed(XW'(sq_dly_q[D_SQ-1])));
  assign m_co  = sat_w(XW'(co_dly_q[D_CO-1]));

  always_comb begin
    mrg_re   = m_sb.re;
    mrg_im   = m_sb.im;
    mrg_flag = m_sb.flag;
    mrg_st   = ST_OK;
    case (m_sb.op)
      OP_DIV, OP_DIVREAL: begin
        if (m_sb.dz) begin
          mrg_re   = '0;
          mrg_im   = '0;
          mrg_flag = 1'b0;
        end else begin
          mrg_re   = m_dre[W-1:0];
          mrg_im   = m_dim[W-1:0];
          mrg_flag = m_dre[W] | m_dim[W];
        end
      end
      OP_ABS: begin
        mrg_re   = m_sq[W-1:0];
        mrg_im   = '0;
        mrg_flag = m_sq[W];
      end
      OP_ARG: begin
        mrg_re   = m_co[W-1:0];
        mrg_im   = '0;
        mrg_flag = m_co[W];
      end
      default: begin
        mrg_flag = m_sb.flag;
      end
    endcase
    if (m_sb.dz) begin
      mrg_st = ST_DZ;
    end else if (mrg_flag) begin
      mrg_st = ST_SAT;
    end
  end

  // output register and skid
  logic        out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic [31:0] out_re_q, out_im_q, skid_re_q, skid_im_q;
  st_e         out_st_q, skid_st_q;
  logic        out_fire, load_out, load_skid;

  assign en        = !skid_v_q;
  assign out_fire  = out_v_q & m_axis_tready;
  assign load_skid = en & vld_q[LAST] & out_v_q & !m_axis_tready;
  assign load_out  = skid_v_q ? out_fire : (vld_q[LAST] & !(out_v_q & !m_axis_tready));
  assign out_v_d   = load_out ? 1'b1 : (out_fire ? 1'b0 : out_v_q);
  assign skid_v_d  = load_skid ? 1'b1 : ((skid_v_q & out_fire) ? 1'b0 : skid_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAST-1:0], s_axis_tvalid};
      end
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_skid) begin
      skid_re_q <= 32'(mrg_re);
      skid_im_q <= 32'(mrg_im);
      skid_st_q <= mrg_st;
    end
    if (load_out) begin
      out_re_q <= skid_v_q ? skid_re_q : 32'(mrg_re);
      out_im_q <= skid_v_q ? skid_im_q : 32'(mrg_im);
      out_st_q <= skid_v_q ? skid_st_q : mrg_st;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_im_q, out_re_q};
  assign m_axis_tuser  = out_st_q;

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !m_axis_tready) |=> skid_v_q)
    else $error("skid result dropped while stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(vld_q[LAST] && out_v_q && !m_axis_tready))
    else $error("skid filled without a stalled result");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_st_q == ST_DZ) |-> (out_re_q == '0 && out_im_q == '0))
    else $error("division by zero result is not zero");

endmodule
